// ----- rtl/rrp_pkg.sv -----
// rrp_pkg: shared widths, character codes and status codes of the resp request parser
// no dependencies; used by the channel interfaces and the top level

package rrp_pkg;

    localparam int DATA_W = 8;
    localparam int OFF_W  = 10;
    localparam int LEN_W  = 16;
    localparam int STAT_W = 2;

    typedef logic [DATA_W-1:0] t_byte;
    typedef logic [OFF_W-1:0]  t_offset;
    typedef logic [LEN_W-1:0]  t_length;
    typedef logic [STAT_W-1:0] t_status;

    // status codes on the result channel
    localparam t_status STATUS_ARG  = 2'd0;
    localparam t_status STATUS_DONE = 2'd1;
    localparam t_status STATUS_ERR  = 2'd2;

    // wire format characters
    localparam t_byte CH_ARRAY = 8'h2A;
    localparam t_byte CH_BULK  = 8'h24;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_ZERO  = 8'h30;

    localparam t_length LEN_MAX = 16'hFFFF;

endpackage

// ----- rtl/rrp_req_if.sv -----
// rrp_req_if: byte request channel (valid/ready plus one buffer byte and its end flag)
// depends on rrp_pkg

interface rrp_req_if import rrp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/rrp_res_if.sv -----
// rrp_res_if: result channel (valid/ready plus status, argument offset and length)
// depends on rrp_pkg

interface rrp_res_if import rrp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    t_offset arg_offset;
    t_length arg_length;

    modport source (output valid, output status, output arg_offset, output arg_length,
                    input ready);
    modport sink   (input valid, input status, input arg_offset, input arg_length,
                    output ready);
endinterface

// ----- rtl/resp_request_parser.sv -----
// resp_request_parser: byte-serial parser for requests in the resp wire format
// depends on rrp_pkg, rrp_req_if and rrp_res_if
//
//   port     dir   modport  carries
//   i_req    in    sink     data_byte, last_byte: one buffer byte per request
//   o_res    out   source   status, arg_offset, arg_length: zero or one per byte
//
// one byte is taken every cycle; its result sits in the output register the next cycle.
// i_req.ready is low only while a result is held and o_res is stalled; bytes that make
// no result still need a free or draining output register.
// reset (i_rst_n low, synchronous) returns to expecting a type byte at position zero.
// the open array counts need no reset: only entries below the current depth are read.

module resp_request_parser import rrp_pkg::*; #(
    parameter int BUFFER_BYTES = 1024,
    parameter int MAX_DEPTH    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrp_req_if.sink     i_req,
    rrp_res_if.source   o_res
);

    localparam int POS_W = $clog2(BUFFER_BYTES);
    localparam int EXT_W = (POS_W + 1 > OFF_W) ? POS_W + 1 : OFF_W;
    localparam int DEP_W = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ACC_W = LEN_W + 4;

    typedef enum logic [3:0] {
        PH_TYPE,
        PH_ANUM,
        PH_BNUM,
        PH_ALF,
        PH_BLF,
        PH_PAY,
        PH_TR1,
        PH_TR2,
        PH_IDLE
    } t_phase;

    t_phase             r_phase, n_phase;
    t_length            r_acc, n_acc;
    logic [POS_W-1:0]   r_pos, n_pos;
    t_length            r_pay, n_pay;
    logic [DEP_W-1:0]   r_depth, n_depth;
    t_length            r_pend [MAX_DEPTH];

    logic               r_valid;
    t_status            r_status;
    t_offset            r_offset;
    t_length            r_length;

    logic               res_vld;
    t_status            res_status;
    t_offset            res_offset;
    t_length            res_length;

    logic               pend_we;
    logic [IDX_W-1:0]   pend_idx;
    t_length            pend_wdata;

    logic               pop_found;
    logic [IDX_W-1:0]   pop_idx;
    logic               accept;
    logic               last;
    t_byte              digit;
    logic [ACC_W-1:0]   acc_sum;
    logic [EXT_W-1:0]   off_ext;

    assign i_req.ready = !r_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign o_res.valid      = r_valid;
    assign o_res.status     = r_status;
    assign o_res.arg_offset = r_offset;
    assign o_res.arg_length = r_length;

    assign last    = i_req.last_byte || (r_pos == POS_W'(BUFFER_BYTES - 1));
    assign digit   = i_req.data_byte - CH_ZERO;
    assign acc_sum = {r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + ACC_W'(digit);
    assign off_ext = EXT_W'(r_pos) + EXT_W'(1);

    // innermost open array whose count does not run out when an element ends
    always_comb begin
        pop_found = 1'b0;
        pop_idx   = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if ((DEP_W'(i) < r_depth) && (r_pend[i] != t_length'(1))) begin
                pop_found = 1'b1;
                pop_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_pos      = r_pos;
        n_pay      = r_pay;
        n_depth    = r_depth;
        res_vld    = 1'b0;
        res_status = STATUS_ARG;
        res_offset = '0;
        res_length = '0;
        pend_we    = 1'b0;
        pend_idx   = pop_idx;
        pend_wdata = r_pend[pop_idx] - t_length'(1);

        case (r_phase)
            PH_TYPE: begin
                n_acc = '0;
                if (i_req.data_byte == CH_ARRAY) begin
                    n_phase = PH_ANUM;
                end else if (i_req.data_byte == CH_BULK) begin
                    n_phase = PH_BNUM;
                end else begin
                    res_vld    = 1'b1;
                    res_status = STATUS_ERR;
                    n_phase    = PH_IDLE;
                end
            end
            PH_ANUM, PH_BNUM: begin
                if (i_req.data_byte == CH_CR) begin
                    n_phase = (r_phase == PH_ANUM) ? PH_ALF : PH_BLF;
                end else begin
                    n_acc = (acc_sum > ACC_W'(LEN_MAX)) ? LEN_MAX : acc_sum[LEN_W-1:0];
                end
            end
            PH_ALF: begin
                if (r_acc == '0) begin
                    // empty array ends its element right away
                    if (pop_found) begin
                        pend_we = 1'b1;
                        n_depth = DEP_W'(pop_idx) + DEP_W'(1);
                        n_phase = PH_TYPE;
                    end else begin
                        n_depth    = '0;
                        n_phase    = PH_IDLE;
                        res_vld    = 1'b1;
                        res_status = STATUS_DONE;
                    end
                end else if (r_depth >= DEP_W'(MAX_DEPTH)) begin
                    res_vld    = 1'b1;
                    res_status = STATUS_ERR;
                    n_phase    = PH_IDLE;
                end else begin
                    pend_we    = 1'b1;
                    pend_idx   = IDX_W'(r_depth);
                    pend_wdata = r_acc;
                    n_depth    = r_depth + DEP_W'(1);
                    n_phase    = PH_TYPE;
                end
            end
            PH_BLF: begin
                res_vld    = 1'b1;
                res_status = STATUS_ARG;
                res_offset = off_ext[OFF_W-1:0];
                res_length = r_acc;
                n_pay      = r_acc;
                n_phase    = (r_acc != '0) ? PH_PAY : PH_TR1;
            end
            PH_PAY: begin
                n_pay = r_pay - t_length'(1);
                if (r_pay == t_length'(1)) begin
                    n_phase = PH_TR1;
                end
            end
            PH_TR1: begin
                n_phase = PH_TR2;
            end
            PH_TR2: begin
                if (pop_found) begin
                    pend_we = 1'b1;
                    n_depth = DEP_W'(pop_idx) + DEP_W'(1);
                    n_phase = PH_TYPE;
                end else begin
                    n_depth    = '0;
                    n_phase    = PH_IDLE;
                    res_vld    = 1'b1;
                    res_status = STATUS_DONE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (last) begin
            // unfinished request at buffer end overrides any argument report
            if (n_phase != PH_IDLE) begin
                res_vld    = 1'b1;
                res_status = STATUS_ERR;
                res_offset = '0;
                res_length = '0;
            end
            n_phase = PH_TYPE;
            n_acc   = '0;
            n_pos   = '0;
            n_pay   = '0;
            n_depth = '0;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_acc   <= '0;
            r_pos   <= '0;
            r_pay   <= '0;
            r_depth <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_pos   <= n_pos;
                r_pay   <= n_pay;
                r_depth <= n_depth;
            end
            if (accept && res_vld) begin
                r_valid  <= 1'b1;
                r_status <= res_status;
                r_offset <= res_offset;
                r_length <= res_length;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // open array counts
    always_ff @(posedge i_clk) begin
        if (accept && pend_we) begin
            r_pend[pend_idx] <= pend_wdata;
        end
    end

endmodule
